### rtl/trbf_pkg.sv
package trbf_pkg;

  // item operations
  localparam logic [2:0] OP_RASTER     = 3'd0;
  localparam logic [2:0] OP_START_PAGE = 3'd1;
  localparam logic [2:0] OP_END_PAGE   = 3'd2;
  localparam logic [2:0] OP_END_JOB    = 3'd3;
  localparam logic [2:0] OP_START_JOB  = 3'd4;
  localparam logic [2:0] OP_PULL       = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
  localparam logic [1:0] REG_TEAR_FEED      = 2'd1;
  localparam logic [1:0] REG_TRIM_ENABLE    = 2'd2;

  // printer command bytes
  localparam logic [7:0] CMD_ESC      = 8'h1B;
  localparam logic [7:0] CMD_GS       = 8'h1D;
  localparam logic [7:0] CMD_FEED_J   = 8'h4A;
  localparam logic [7:0] CMD_INIT_AT  = 8'h40;
  localparam logic [7:0] CMD_IMAGE_V  = 8'h76;
  localparam logic [7:0] CMD_IMAGE_M0 = 8'h30;
  localparam logic [7:0] CMD_ZERO     = 8'h00;
  localparam logic [7:0] CMD_CUT_V    = 8'h56;
  localparam logic [7:0] CMD_CUT_MODE = 8'h01;

  // configuration reset values
  localparam logic [7:0] RST_BYTES_PER_LINE = 8'd72;
  localparam logic [7:0] RST_TEAR_FEED      = 8'd120;

  // one result item before the memory byte is merged in
  typedef struct packed {
    logic       use_mem;
    logic       burst_end;
    logic       accepted;
    logic [7:0] out_byte;
    logic       out_valid;
  } trbf_res_t;

endpackage

### rtl/thermal_raster_band_formatter_core.sv
// Raster band formatter: raster bytes, page and job ops and pull requests enter on the
// in_ stream, one request per cycle, and every request yields exactly one result on the
// out_ stream. The band store is a single-port-write, single-port-read memory with a
// registered read; the sequencer state sits in registers, so a request can enter
// every cycle and results leave through a pipeline stage and an output register. The
// rate is one request per cycle, limited only by the output side stalling.
// The memory needs no clearing pass after reset.
module thermal_raster_band_formatter_core #(
  parameter int MAX_LINES      = 512,
  parameter int MAX_LINE_BYTES = 128,
  parameter int FEED_CHUNK     = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op [2:0], raster_byte [10:3], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_valid [0], out_byte [8:1], accepted [9],
                                  // burst_end [10], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int STORE   = MAX_LINES * MAX_LINE_BYTES;
  localparam int ADDR_W  = $clog2(STORE);
  localparam int LINES_W = $clog2(MAX_LINES + 1);
  localparam int BPL_W   = $clog2(MAX_LINE_BYTES + 1);
  localparam int BIL_W   = $clog2(MAX_LINE_BYTES);
  localparam int PROD_W  = LINES_W + BPL_W;
  localparam int CNT_W   = $clog2(STORE + 11);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FEED, PH_BAND_ONLY, PH_BAND_FEED, PH_RESET, PH_TEAR, PH_CUT
  } phase_t;

  // configuration
  logic [7:0] bpl_cfg_r;
  logic [7:0] tear_r;
  logic       trim_r;

  // sequencer state
  logic [15:0]        blank_run_r, blank_run_nxt;
  logic [LINES_W-1:0] band_lines_r, band_lines_nxt;
  logic [BIL_W-1:0]   byte_in_line_r, byte_in_line_nxt;
  logic               line_nonblank_r, line_nonblank_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   emit_count_r, emit_count_nxt;

  // pipeline and output
  logic                p_valid_r;
  trbf_pkg::trbf_res_t p_res_r, res_nxt;
  logic                out_valid_r;
  logic [15:0]         out_data_r;

  // band store
  logic [7:0]        mem [STORE];
  logic [7:0]        mem_rd_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;

  logic [2:0]  op;
  logic [7:0]  rb;
  logic        accept, out_load;
  logic [BPL_W-1:0]  bpl_eff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   wr_full;
  logic [CNT_W-1:0]  data_c;
  logic [BPL_W-1:0]  bil_inc;
  logic [15:0] bpl16, lines16, feed16, n16;
  logic [7:0]  byte_v;

  assign op       = in_tdata[2:0];
  assign rb       = in_tdata[10:3];
  assign out_load = !out_valid_r || out_tready;
  assign in_tready = !p_valid_r || out_load;
  assign accept   = in_tvalid && in_tready;

  // effective line length
  always_comb begin
    if (bpl_cfg_r == 8'd0) bpl_eff = BPL_W'(1);
    else if (9'(bpl_cfg_r) > 9'(MAX_LINE_BYTES)) bpl_eff = BPL_W'(MAX_LINE_BYTES);
    else bpl_eff = BPL_W'(bpl_cfg_r);
  end

  assign prod    = PROD_W'(band_lines_r) * PROD_W'(bpl_eff);
  assign wr_full = (PROD_W + 1)'(prod) + (PROD_W + 1)'(byte_in_line_r);
  assign data_c  = CNT_W'(prod);
  assign bil_inc = BPL_W'(byte_in_line_r) + BPL_W'(1);
  assign bpl16   = 16'(bpl_eff);
  assign lines16 = 16'(band_lines_r);
  assign feed16  = 16'(FEED_CHUNK);
  assign n16     = (blank_run_r > feed16) ? feed16 : blank_run_r;

  // next state and result of the request at the input
  always_comb begin
    blank_run_nxt     = blank_run_r;
    band_lines_nxt    = band_lines_r;
    byte_in_line_nxt  = byte_in_line_r;
    line_nonblank_nxt = line_nonblank_r;
    phase_nxt         = phase_r;
    emit_count_nxt    = emit_count_r;
    res_nxt           = '0;
    res_nxt.accepted  = 1'b1;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = ADDR_W'(wr_full);
    mem_ra = ADDR_W'(emit_count_r - CNT_W'(8));
    byte_v = 8'd0;

    if (op == trbf_pkg::OP_PULL) begin
      if (phase_r != PH_IDLE) begin
        res_nxt.out_valid = 1'b1;
        case (phase_r)
          PH_FEED: begin
            if (emit_count_r == CNT_W'(0)) begin
              byte_v = trbf_pkg::CMD_ESC; emit_count_nxt = CNT_W'(1);
            end else if (emit_count_r == CNT_W'(1)) begin
              byte_v = trbf_pkg::CMD_FEED_J; emit_count_nxt = CNT_W'(2);
            end else begin
              byte_v = n16[7:0];
              blank_run_nxt = blank_run_r - n16;
              emit_count_nxt = '0;
              if (blank_run_r == n16)
                phase_nxt = (band_lines_r >= LINES_W'(MAX_LINES)) ? PH_BAND_ONLY : PH_IDLE;
            end
          end
          PH_BAND_ONLY, PH_BAND_FEED: begin
            if (emit_count_r < CNT_W'(8)) begin
              case (emit_count_r[2:0])
                3'd0:    byte_v = trbf_pkg::CMD_GS;
                3'd1:    byte_v = trbf_pkg::CMD_IMAGE_V;
                3'd2:    byte_v = trbf_pkg::CMD_IMAGE_M0;
                3'd3:    byte_v = trbf_pkg::CMD_ZERO;
                3'd4:    byte_v = bpl16[7:0];
                3'd5:    byte_v = bpl16[15:8];
                3'd6:    byte_v = lines16[7:0];
                default: byte_v = lines16[15:8];
              endcase
            end else if (emit_count_r < data_c + CNT_W'(8)) begin
              mem_re = accept;
              res_nxt.use_mem = 1'b1;
            end else if (emit_count_r == data_c + CNT_W'(8)) begin
              byte_v = trbf_pkg::CMD_ESC;
            end else if (emit_count_r == data_c + CNT_W'(9)) begin
              byte_v = trbf_pkg::CMD_FEED_J;
            end else begin
              byte_v = trbf_pkg::CMD_ZERO;
            end
            if (emit_count_r >= data_c + CNT_W'(10)) begin
              band_lines_nxt = '0;
              emit_count_nxt = '0;
              phase_nxt = (phase_r == PH_BAND_FEED && blank_run_r != 16'd0) ? PH_FEED
                                                                             : PH_IDLE;
            end else begin
              emit_count_nxt = emit_count_r + CNT_W'(1);
            end
          end
          PH_RESET: begin
            if (emit_count_r == CNT_W'(0)) begin
              byte_v = trbf_pkg::CMD_ESC; emit_count_nxt = CNT_W'(1);
            end else begin
              byte_v = trbf_pkg::CMD_INIT_AT; emit_count_nxt = '0; phase_nxt = PH_IDLE;
            end
          end
          PH_TEAR: begin
            if (emit_count_r == CNT_W'(0)) byte_v = trbf_pkg::CMD_ESC;
            else if (emit_count_r == CNT_W'(1)) byte_v = trbf_pkg::CMD_FEED_J;
            else byte_v = tear_r;
            if (emit_count_r < CNT_W'(2)) emit_count_nxt = emit_count_r + CNT_W'(1);
            else begin
              emit_count_nxt = '0;
              phase_nxt = trim_r ? PH_CUT : PH_RESET;
            end
          end
          PH_CUT: begin
            if (emit_count_r == CNT_W'(0)) byte_v = trbf_pkg::CMD_GS;
            else if (emit_count_r == CNT_W'(1)) byte_v = trbf_pkg::CMD_CUT_V;
            else byte_v = trbf_pkg::CMD_CUT_MODE;
            if (emit_count_r < CNT_W'(2)) emit_count_nxt = emit_count_r + CNT_W'(1);
            else begin
              emit_count_nxt = '0;
              phase_nxt = PH_RESET;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            emit_count_nxt = '0;
          end
        endcase
        res_nxt.out_byte  = byte_v;
        res_nxt.burst_end = (phase_nxt == PH_IDLE);
      end
    end else if (op <= trbf_pkg::OP_START_JOB && phase_r != PH_IDLE) begin
      res_nxt.accepted = 1'b0;
    end else if (op == trbf_pkg::OP_RASTER) begin
      // store the byte and close the line when full
      mem_we = accept && (wr_full < (PROD_W + 1)'(STORE));
      if (rb != 8'd0) line_nonblank_nxt = 1'b1;
      byte_in_line_nxt = BIL_W'(bil_inc);
      if (bil_inc >= bpl_eff) begin
        byte_in_line_nxt = '0;
        if (line_nonblank_r || rb != 8'd0) begin
          line_nonblank_nxt = 1'b0;
          if (band_lines_r < LINES_W'(MAX_LINES)) band_lines_nxt = band_lines_r + LINES_W'(1);
          emit_count_nxt = '0;
          if (blank_run_r != 16'd0) phase_nxt = PH_FEED;
          else phase_nxt = (band_lines_nxt >= LINES_W'(MAX_LINES)) ? PH_BAND_ONLY : PH_IDLE;
        end else begin
          if (band_lines_r != '0) begin
            phase_nxt = PH_BAND_ONLY; emit_count_nxt = '0;
          end
          if (blank_run_r != 16'hFFFF) blank_run_nxt = blank_run_r + 16'd1;
        end
      end
    end else if (op == trbf_pkg::OP_END_PAGE) begin
      byte_in_line_nxt = '0;
      line_nonblank_nxt = 1'b0;
      emit_count_nxt = '0;
      if (band_lines_r != '0) phase_nxt = PH_BAND_FEED;
      else if (blank_run_r != 16'd0) phase_nxt = PH_FEED;
    end else if (op == trbf_pkg::OP_START_PAGE || op == trbf_pkg::OP_END_JOB ||
                 op == trbf_pkg::OP_START_JOB) begin
      blank_run_nxt = '0;
      band_lines_nxt = '0;
      byte_in_line_nxt = '0;
      line_nonblank_nxt = 1'b0;
      if (op == trbf_pkg::OP_END_JOB) begin
        emit_count_nxt = '0;
        if (tear_r != 8'd0) phase_nxt = PH_TEAR;
        else if (trim_r) phase_nxt = PH_CUT;
        else phase_nxt = PH_RESET;
      end else if (op == trbf_pkg::OP_START_JOB) begin
        emit_count_nxt = '0;
        phase_nxt = PH_RESET;
      end
    end
  end

  // band store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= rb;
    if (mem_re) mem_rd_r <= mem[mem_ra];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_cfg_r <= trbf_pkg::RST_BYTES_PER_LINE;
      tear_r    <= trbf_pkg::RST_TEAR_FEED;
      trim_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        trbf_pkg::REG_BYTES_PER_LINE: bpl_cfg_r <= cfg_wdata;
        trbf_pkg::REG_TEAR_FEED:      tear_r    <= cfg_wdata;
        trbf_pkg::REG_TRIM_ENABLE:    trim_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer state and result pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_run_r     <= '0;
      band_lines_r    <= '0;
      byte_in_line_r  <= '0;
      line_nonblank_r <= 1'b0;
      phase_r         <= PH_IDLE;
      emit_count_r    <= '0;
      p_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        blank_run_r     <= blank_run_nxt;
        band_lines_r    <= band_lines_nxt;
        byte_in_line_r  <= byte_in_line_nxt;
        line_nonblank_r <= line_nonblank_nxt;
        phase_r         <= phase_nxt;
        emit_count_r    <= emit_count_nxt;
      end
      if (in_tready) p_valid_r <= in_tvalid;
      if (out_load) out_valid_r <= p_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) p_res_r <= res_nxt;
    if (out_load && p_valid_r)
      out_data_r <= {5'd0, p_res_r.burst_end, p_res_r.accepted,
                     p_res_r.use_mem ? mem_rd_r : p_res_r.out_byte, p_res_r.out_valid};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/trbf_checker.sv
module trbf_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // no byte without a valid flag
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("byte present without valid flag");

  // queue end only on a delivered byte
  a_burst_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[0] && out_tdata[9])
    else $error("burst end without byte");

  // refused request carries no byte
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> !out_tdata[0] && !out_tdata[10])
    else $error("refused request carries a byte");

endmodule

bind thermal_raster_band_formatter_core trbf_assertions u_trbf_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
